>>> rtl/tbs_pkg.sv
// ----------------------------------------------------------------------------
// Texture bilinear sampler package
// Widths, register codes and the structures that the sampler's modules share.
// ----------------------------------------------------------------------------
package tbs_pkg;

  // Stream and configuration port widths
  localparam int InDataW  = 128;
  localparam int OutDataW = 48;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;

  // Integer texel coordinate after scaling, signed
  localparam int CoordW = 27;
  // Texel index along one axis, width of the size registers
  localparam int IdxW   = 9;

  // Shared multiplier: signed A operand, unsigned B operand, signed product
  localparam int MulAW = 34;
  localparam int MulBW = 17;
  localparam int MulPW = MulAW + MulBW + 1;

  // Channel, texel, weight and accumulator widths
  localparam int ChW  = 16;
  localparam int TexW = 3 * ChW;
  localparam int WgtW = 33;
  localparam int AccW = 48;

  // Configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_BORDER,
    REG_FILTER,
    REG_EXPOSURE
  } cfg_reg_e;

  // Where a product goes once it leaves the multiplier
  typedef enum logic [2:0] {
    DST_NONE,
    DST_SX,
    DST_SY,
    DST_WGT,
    DST_ACC,
    DST_EXP
  } mul_dst_e;

  typedef struct packed {
    mul_dst_e   dst;
    logic [1:0] idx;
  } mul_tag_t;

  // Result of the border unit: a pulse and the two neighbouring indexes
  typedef struct packed {
    logic            done;
    logic [IdxW-1:0] idx0;
    logic [IdxW-1:0] idx1;
  } border_res_t;

endpackage

>>> rtl/tbs_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module tbs_ram #(
  parameter int Width = 48,
  parameter int Depth = 65536,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Storage array with a registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tbs_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed by unsigned multiply with a registered product. A tag travels with
// each operation so that the sequencer knows where the product belongs.
// ----------------------------------------------------------------------------
module tbs_mul (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [tbs_pkg::MulAW-1:0]   a_i,
  input  logic        [tbs_pkg::MulBW-1:0]   b_i,
  input  tbs_pkg::mul_tag_t                  tag_i,
  output logic signed [tbs_pkg::MulPW-1:0]   p_o,
  output tbs_pkg::mul_tag_t                  tag_o
);
  import tbs_pkg::*;

  logic signed [MulPW-1:0] a_ext;
  logic signed [MulPW-1:0] b_ext;
  logic signed [MulPW-1:0] p_d;
  logic signed [MulPW-1:0] p_q;
  mul_tag_t                tag_q;

  // Operands extended to the full product width before the multiply
  assign a_ext = MulPW'(a_i);
  assign b_ext = MulPW'($signed({1'b0, b_i}));
  assign p_d   = a_ext * b_ext;

  // Product register
  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  // Tag register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '{dst: DST_NONE, idx: '0};
    end else begin
      tag_q <= tag_i;
    end
  end

  assign p_o   = p_q;
  assign tag_o = tag_q;

endmodule

>>> rtl/tbs_border.sv
// ----------------------------------------------------------------------------
// Border unit
// Maps an integer texel coordinate and its right or lower neighbour into
// the image, either by clamping to the edge or by a non-negative modulo.
// The modulo is a restoring remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module tbs_border (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                wrap_i,
  input  logic signed [tbs_pkg::CoordW-1:0]   coord_i,
  input  logic        [tbs_pkg::IdxW-1:0]     n_i,
  output tbs_pkg::border_res_t                res_o
);
  import tbs_pkg::*;

  localparam int CntW = $clog2(CoordW + 1);

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_DIV,
    BS_FIX
  } bstate_e;

  bstate_e            state_q;
  logic [CntW-1:0]    cnt_q;
  logic [CoordW-1:0]  mag_q;
  logic [IdxW-1:0]    rem_q;
  logic               neg_q;
  logic [IdxW-1:0]    n_q;
  border_res_t        res_q;

  logic                     coord_neg;
  logic [CoordW-1:0]        coord_mag;
  logic signed [CoordW:0]   coord_p1;
  logic signed [CoordW:0]   n_ext;
  logic [IdxW-1:0]          clamp0;
  logic [IdxW-1:0]          clamp1;
  logic [IdxW:0]            trial;
  logic [IdxW-1:0]          rem_next;
  logic [IdxW-1:0]          r_fix;
  logic [IdxW:0]            r_inc;
  logic [IdxW-1:0]          r_next;

  // Sign and magnitude of the incoming coordinate
  assign coord_neg = coord_i[CoordW-1];
  assign coord_mag = coord_neg ? CoordW'(-coord_i) : CoordW'(coord_i);
  assign coord_p1  = $signed({coord_i[CoordW-1], coord_i}) + (CoordW+1)'(1);
  assign n_ext     = $signed({{(CoordW+1-IdxW){1'b0}}, n_i});

  // Clamp to the edge for the coordinate and its neighbour
  always_comb begin
    if (coord_neg) begin
      clamp0 = '0;
    end else if ($signed({coord_i[CoordW-1], coord_i}) >= n_ext) begin
      clamp0 = n_i - IdxW'(1);
    end else begin
      clamp0 = coord_i[IdxW-1:0];
    end
    if (coord_p1[CoordW]) begin
      clamp1 = '0;
    end else if (coord_p1 >= n_ext) begin
      clamp1 = n_i - IdxW'(1);
    end else begin
      clamp1 = coord_p1[IdxW-1:0];
    end
  end

  // One restoring step of the remainder
  assign trial    = {rem_q, mag_q[CoordW-1]};
  assign rem_next = (trial >= {1'b0, n_q}) ? IdxW'(trial - {1'b0, n_q}) : trial[IdxW-1:0];

  // A negative dividend with a non-zero remainder folds back into range
  assign r_fix  = (neg_q && (rem_q != '0)) ? (n_q - rem_q) : rem_q;
  assign r_inc  = {1'b0, r_fix} + (IdxW+1)'(1);
  assign r_next = (r_inc == {1'b0, n_q}) ? '0 : r_inc[IdxW-1:0];

  // Sequencer for the remainder and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
      cnt_q   <= '0;
      res_q   <= '0;
    end else begin
      res_q.done <= 1'b0;
      unique case (state_q)
        BS_IDLE: begin
          if (start_i) begin
            if (wrap_i) begin
              mag_q   <= coord_mag;
              neg_q   <= coord_neg;
              n_q     <= n_i;
              rem_q   <= '0;
              cnt_q   <= CntW'(CoordW);
              state_q <= BS_DIV;
            end else begin
              res_q.done <= 1'b1;
              res_q.idx0 <= clamp0;
              res_q.idx1 <= clamp1;
            end
          end
        end
        BS_DIV: begin
          rem_q <= rem_next;
          mag_q <= {mag_q[CoordW-2:0], 1'b0};
          cnt_q <= cnt_q - CntW'(1);
          if (cnt_q == CntW'(1)) begin
            state_q <= BS_FIX;
          end
        end
        BS_FIX: begin
          res_q.done <= 1'b1;
          res_q.idx0 <= r_fix;
          res_q.idx1 <= r_next;
          state_q    <= BS_IDLE;
        end
        default: begin
          state_q <= BS_IDLE;
        end
      endcase
    end
  end

  assign res_o = res_q;

endmodule

>>> rtl/texture_bilinear_sampler_core.sv
// ----------------------------------------------------------------------------
// Texture bilinear sampler core
// Texel store with write and sample requests on one input stream. A sample
// scales signed Q16.16 u and 1-v by the image size, maps the texel
// coordinates through clamp or repeat, fetches one or four texels and blends
// them with 33-bit weights made from 16-bit fractions, then applies an 8.8
// exposure with saturation. Every request gives exactly one result; a write
// gives an acknowledge with zero channels. One request is worked on at a
// time, and the input is ready only between requests. All products go
// through one shared multiplier and all four texel reads through the single
// port of the texel store; repeat mode adds two bit-serial remainders (27
// dividend bits each). A finished result waits in the output register while
// the next request is taken. The store has no reset: texels must be written
// before they are sampled.
// ----------------------------------------------------------------------------
module texture_bilinear_sampler_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Requests
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // From bit 0: u_coord[31:0], v_coord[63:32], texel_col[71:64],
  // texel_row[79:72], texel_red[95:80], texel_green[111:96], texel_blue[127:112]
  input  logic [tbs_pkg::InDataW-1:0]     s_axis_tdata_i,
  // From bit 0: req_type
  input  logic [0:0]                      s_axis_tuser_i,
  // Results
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // From bit 0: out_red[15:0], out_green[31:16], out_blue[47:32]
  output logic [tbs_pkg::OutDataW-1:0]    m_axis_tdata_o,
  // From bit 0: is_sample
  output logic [0:0]                      m_axis_tuser_o,
  // Configuration writes
  input  logic                            cfg_we_i,
  input  logic [tbs_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  logic [tbs_pkg::CfgDataW-1:0]    cfg_wdata_i
);
  import tbs_pkg::*;

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [IdxW-1:0] MaxW = (MAX_WIDTH > 511) ? 9'd511 : IdxW'(MAX_WIDTH);
  localparam logic [IdxW-1:0] MaxH = (MAX_HEIGHT > 511) ? 9'd511 : IdxW'(MAX_HEIGHT);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MX,
    ST_MY,
    ST_GAP,
    ST_BX,
    ST_BXW,
    ST_BY,
    ST_BYW,
    ST_WGT,
    ST_RD,
    ST_MAC,
    ST_EXP,
    ST_TAIL,
    ST_DONE
  } state_e;

  // Configuration registers
  logic [IdxW-1:0]  width_q;
  logic [IdxW-1:0]  height_q;
  logic             border_q;
  logic             filter_q;
  logic [ChW-1:0]   expo_q;

  // Sequencer state and registered outputs
  state_e           state_q;
  logic [1:0]       j_q;
  logic [1:0]       k_q;
  logic             sample_q;
  logic             m_valid_q;
  logic [TexW-1:0]  m_data_q;
  logic             m_user_q;

  // Datapath registers
  logic signed [31:0]        u_q;
  logic signed [32:0]        v_q;
  logic signed [CoordW-1:0]  cx_q;
  logic signed [CoordW-1:0]  cy_q;
  logic [15:0]               fu_q;
  logic [15:0]               fv_q;
  logic [IdxW-1:0]           bx0_q;
  logic [IdxW-1:0]           bx1_q;
  logic [IdxW-1:0]           by0_q;
  logic [IdxW-1:0]           by1_q;
  logic [WgtW-1:0]           wgt_q [4];
  logic [AccW-1:0]           acc_q [3];
  logic [ChW-1:0]            res_q [3];

  // Combinational signals
  logic                      in_fire;
  logic                      req_sample;
  logic [IdxW-1:0]           w_eff;
  logic [IdxW-1:0]           h_eff;
  logic [7:0]                wr_col;
  logic [7:0]                wr_row;
  logic                      wr_in_range;
  logic [31:0]               wr_lin;
  logic [31:0]               rd_lin;
  logic [IdxW-1:0]           rd_x;
  logic [IdxW-1:0]           rd_y;
  logic                      ram_we;
  logic                      ram_re;
  logic [AddrW-1:0]          ram_addr;
  logic [TexW-1:0]           ram_rdata;
  logic [16:0]               gu;
  logic [16:0]               gv;
  logic [ChW-1:0]            ch_k;
  logic [AccW-1:0]           acc_k;
  logic [AccW-1:0]           acc_rnd;
  logic [ChW-1:0]            c_k;
  logic signed [MulAW-1:0]   mul_a;
  logic [MulBW-1:0]          mul_b;
  mul_tag_t                  mul_tag;
  logic signed [MulPW-1:0]   prod;
  mul_tag_t                  prod_tag;
  logic signed [MulPW-1:0]   half_off;
  logic signed [MulPW-1:0]   prod_t;
  logic [32:0]               exp_sum;
  logic [ChW-1:0]            exp_res;
  logic                      bord_start;
  logic signed [CoordW-1:0]  bord_coord;
  logic [IdxW-1:0]           bord_n;
  border_res_t               bord_res;
  logic [1:0]                last_j;

  assign in_fire    = s_axis_tvalid_i && s_axis_tready_o;
  assign req_sample = s_axis_tuser_i[0];
  assign last_j     = filter_q ? 2'd3 : 2'd0;

  // Image size in use: zero counts as one, oversize is cut to the store size
  always_comb begin
    if (width_q == '0) begin
      w_eff = IdxW'(1);
    end else if ({23'd0, width_q} > 32'(MAX_WIDTH)) begin
      w_eff = MaxW;
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = IdxW'(1);
    end else if ({23'd0, height_q} > 32'(MAX_HEIGHT)) begin
      h_eff = MaxH;
    end else begin
      h_eff = height_q;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 9'd256;
      border_q <= 1'b1;
      filter_q <= 1'b1;
      expo_q   <= 16'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_WIDTH:    width_q  <= cfg_wdata_i[IdxW-1:0];
        REG_HEIGHT:   height_q <= cfg_wdata_i[IdxW-1:0];
        REG_BORDER:   border_q <= cfg_wdata_i[0];
        REG_FILTER:   filter_q <= cfg_wdata_i[0];
        REG_EXPOSURE: expo_q   <= cfg_wdata_i[ChW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Texel store addressing: writes at acceptance, reads in the fetch step
  assign wr_col      = s_axis_tdata_i[71:64];
  assign wr_row      = s_axis_tdata_i[79:72];
  assign wr_in_range = ({24'd0, wr_col} < 32'(MAX_WIDTH)) &&
                       ({24'd0, wr_row} < 32'(MAX_HEIGHT));
  assign wr_lin      = {24'd0, wr_row} * 32'(MAX_WIDTH) + {24'd0, wr_col};
  assign rd_x        = j_q[1] ? bx1_q : bx0_q;
  assign rd_y        = j_q[0] ? by1_q : by0_q;
  assign rd_lin      = {23'd0, rd_y} * 32'(MAX_WIDTH) + {23'd0, rd_x};
  assign ram_we      = in_fire && !req_sample && wr_in_range;
  assign ram_re      = (state_q == ST_RD);
  assign ram_addr    = ram_we ? AddrW'(wr_lin) : AddrW'(rd_lin);

  tbs_ram #(
    .Width (TexW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (s_axis_tdata_i[127:80]),
    .rdata_o (ram_rdata)
  );

  // Border unit, shared by both axes
  assign bord_start = (state_q == ST_BX) || (state_q == ST_BY);
  assign bord_coord = (state_q == ST_BY) ? cy_q : cx_q;
  assign bord_n     = (state_q == ST_BY) ? h_eff : w_eff;

  tbs_border u_border (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (bord_start),
    .wrap_i  (border_q),
    .coord_i (bord_coord),
    .n_i     (bord_n),
    .res_o   (bord_res)
  );

  // Complementary weights and per-channel selections
  assign gu = 17'h10000 - {1'b0, fu_q};
  assign gv = 17'h10000 - {1'b0, fv_q};

  always_comb begin
    unique case (k_q)
      2'd1: begin
        ch_k  = ram_rdata[2*ChW-1:ChW];
        acc_k = acc_q[1];
      end
      2'd2: begin
        ch_k  = ram_rdata[3*ChW-1:2*ChW];
        acc_k = acc_q[2];
      end
      default: begin
        ch_k  = ram_rdata[ChW-1:0];
        acc_k = acc_q[0];
      end
    endcase
  end

  // Weighted sum rounded half up from units of 2^-32
  assign acc_rnd = acc_k + AccW'(48'h0000_8000_0000);
  assign c_k     = acc_rnd[AccW-1:32];

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_tag = '{dst: DST_NONE, idx: '0};
    unique case (state_q)
      ST_MX: begin
        mul_a   = MulAW'(u_q);
        mul_b   = MulBW'(w_eff);
        mul_tag = '{dst: DST_SX, idx: '0};
      end
      ST_MY: begin
        mul_a   = MulAW'(v_q);
        mul_b   = MulBW'(h_eff);
        mul_tag = '{dst: DST_SY, idx: '0};
      end
      ST_WGT: begin
        mul_a   = $signed(MulAW'(j_q[1] ? {1'b0, fu_q} : gu));
        mul_b   = j_q[0] ? {1'b0, fv_q} : gv;
        mul_tag = '{dst: DST_WGT, idx: j_q};
      end
      ST_MAC: begin
        mul_a   = $signed(MulAW'(wgt_q[j_q]));
        mul_b   = MulBW'(ch_k);
        mul_tag = '{dst: DST_ACC, idx: k_q};
      end
      ST_EXP: begin
        mul_a   = $signed(MulAW'(c_k));
        mul_b   = MulBW'(expo_q);
        mul_tag = '{dst: DST_EXP, idx: k_q};
      end
      default: begin
      end
    endcase
  end

  tbs_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .tag_i  (mul_tag),
    .p_o    (prod),
    .tag_o  (prod_tag)
  );

  // Scaled coordinate less half a texel when blending
  assign half_off = filter_q ? MulPW'(32768) : '0;
  assign prod_t   = prod - half_off;

  // Exposure in 8.8, rounded half up and saturated
  assign exp_sum = {1'b0, prod[31:0]} + 33'd128;
  assign exp_res = (exp_sum[32:24] != '0) ? 16'hFFFF : exp_sum[23:8];

  // Datapath registers, loaded from requests and from the multiplier
  always_ff @(posedge clk_i) begin
    if (in_fire && req_sample) begin
      u_q <= $signed(s_axis_tdata_i[31:0]);
      v_q <= 33'sh10000 - $signed({s_axis_tdata_i[63], s_axis_tdata_i[63:32]});
    end
    if (state_q == ST_MX) begin
      for (int k = 0; k < 3; k++) begin
        acc_q[k] <= '0;
      end
    end
    if ((state_q == ST_BXW) && bord_res.done) begin
      bx0_q <= bord_res.idx0;
      bx1_q <= bord_res.idx1;
    end
    if ((state_q == ST_BYW) && bord_res.done) begin
      by0_q <= bord_res.idx0;
      by1_q <= bord_res.idx1;
    end
    unique case (prod_tag.dst)
      DST_SX: begin
        cx_q <= prod_t[16 +: CoordW];
        fu_q <= filter_q ? prod_t[15:0] : '0;
      end
      DST_SY: begin
        cy_q <= prod_t[16 +: CoordW];
        fv_q <= filter_q ? prod_t[15:0] : '0;
      end
      DST_WGT: begin
        wgt_q[prod_tag.idx] <= prod[WgtW-1:0];
      end
      DST_ACC: begin
        for (int k = 0; k < 3; k++) begin
          if (prod_tag.idx == 2'(k)) begin
            acc_q[k] <= acc_q[k] + prod[AccW-1:0];
          end
        end
      end
      DST_EXP: begin
        for (int k = 0; k < 3; k++) begin
          if (prod_tag.idx == 2'(k)) begin
            res_q[k] <= exp_res;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Request sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      j_q       <= '0;
      k_q       <= '0;
      sample_q  <= 1'b0;
      m_valid_q <= 1'b0;
      m_user_q  <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            sample_q <= req_sample;
            state_q  <= req_sample ? ST_MX : ST_DONE;
          end
        end
        ST_MX:   state_q <= ST_MY;
        ST_MY:   state_q <= ST_GAP;
        ST_GAP:  state_q <= ST_BX;
        ST_BX:   state_q <= ST_BXW;
        ST_BXW: begin
          if (bord_res.done) begin
            state_q <= ST_BY;
          end
        end
        ST_BY:   state_q <= ST_BYW;
        ST_BYW: begin
          if (bord_res.done) begin
            j_q     <= '0;
            state_q <= ST_WGT;
          end
        end
        ST_WGT: begin
          j_q <= j_q + 2'd1;
          if (j_q == 2'd3) begin
            state_q <= ST_RD;
          end
        end
        ST_RD: begin
          k_q     <= '0;
          state_q <= ST_MAC;
        end
        ST_MAC: begin
          if (k_q == 2'd2) begin
            k_q <= '0;
            if (j_q == last_j) begin
              state_q <= ST_EXP;
            end else begin
              j_q     <= j_q + 2'd1;
              state_q <= ST_RD;
            end
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
        ST_EXP: begin
          if (k_q == 2'd2) begin
            k_q     <= '0;
            state_q <= ST_TAIL;
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
        ST_TAIL: state_q <= ST_DONE;
        ST_DONE: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            m_user_q  <= sample_q;
            m_data_q  <= sample_q ? {res_q[2], res_q[1], res_q[0]} : '0;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

`ifndef SYNTHESIS
  // The border unit only reports while the sequencer waits for it
  a_border_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bord_res.done |-> (state_q == ST_BXW || state_q == ST_BYW))
    else $error("border result arrived outside a wait step");

  // A texel write goes straight to the result step
  a_write_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !req_sample) |=> (state_q == ST_DONE))
    else $error("texel write did not go to the result step");

  // A new result appears only from the result step
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == ST_DONE))
    else $error("result valid rose outside the result step");

  // Accumulating products land only while the blend or exposure runs
  a_acc_in_blend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prod_tag.dst == DST_ACC) |->
      (state_q == ST_MAC || state_q == ST_RD || state_q == ST_EXP))
    else $error("accumulating product outside the blend");
`endif

endmodule
